@@ src/bmk_pkg.sv @@
// Shared types, constants and helpers for the BCD mm:ss keypad clock.
`default_nettype none
package bmk_pkg;

    localparam int TICK_W  = 12;
    localparam int DIGIT_W = 4;
    localparam int IDX_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [TICK_W-1:0]  TICK_LIMIT_RESET        = 12'd3980;
    localparam logic [DIGIT_W-1:0] MINUTE_TENS_LIMIT_RESET = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_TENS_LIMIT = 2'd1;

    // item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_KEY   = 2'd1;
    localparam logic [1:0] MODE_EDIT  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [7:0] KEY_CANCEL = 8'h2A;
    localparam logic [7:0] KEY_COMMIT = 8'h23;
    localparam logic [7:0] KEY_ZERO   = 8'h30;
    localparam logic [7:0] KEY_NINE   = 8'h39;

    localparam logic [IDX_W-1:0] ENTRY_FULL = 3'd4;

    localparam logic [DIGIT_W-1:0] LIMIT_UNITS = 4'd10;
    localparam logic [DIGIT_W-1:0] LIMIT_TENS  = 4'd6;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [3:0] minute_tens;
        logic [3:0] minute_units;
        logic [3:0] second_tens;
        logic [3:0] second_units;
        logic       editing;
        logic [2:0] entered_count;
        logic       second_passed;
        logic       committed;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_limit;
        logic [DIGIT_W-1:0] minute_tens_limit;
    } cfg_t;

    // Increment a digit within 4 bits, wrap to zero at or above limit.
    // Returns {carry, digit}.
    function automatic logic [DIGIT_W:0] bump_digit(input logic [DIGIT_W-1:0] d,
                                                     input logic [DIGIT_W-1:0] limit);
        logic [DIGIT_W-1:0] n;
        n = d + 4'd1;
        if (n >= limit)
        begin
            return {1'b1, {DIGIT_W{1'b0}}};
        end
        return {1'b0, n};
    endfunction

endpackage
`default_nettype wire

@@ src/bcd_mmss_clock_keypad_set.sv @@
// Top level of the BCD mm:ss clock with keypad time setting.
`default_nettype none
// Accepts one item per clock cycle while the output side keeps up (timer
// tick, key press, begin edit or clear) and returns exactly one result item
// per input item, in order. An item passes an input register and then the
// combinational prescaler/digit-cascade/edit update in the core, which writes
// the result register and raises out_valid; the update waits while an
// unaccepted result holds that register. The output register lets a new item
// enter while a finished result waits. tick_limit resets to 3980 and
// minute_tens_limit to 9; write them only while idle.
module bcd_mmss_clock_keypad_set (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire bmk_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output bmk_pkg::out_item_t                  out_item,
    input  wire logic                           cfg_we,
    input  wire logic [bmk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bmk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmk_pkg::*;

    cfg_t     cfg;
    logic     item_vld;
    in_item_t item;
    logic     take;

    bmk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bmk_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .item_vld (item_vld),
        .item     (item),
        .take     (take)
    );

    bmk_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_vld  (item_vld),
        .item      (item),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

@@ src/bmk_cfg.sv @@
// Configuration registers: tick limit and minute tens limit.
`default_nettype none
module bmk_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bmk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmk_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bmk_pkg::cfg_t                        cfg
);
    import bmk_pkg::*;

    logic [TICK_W-1:0]  tick_limit_reg;
    logic [DIGIT_W-1:0] mt_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg <= TICK_LIMIT_RESET;
            mt_limit_reg   <= MINUTE_TENS_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_LIMIT:        tick_limit_reg <= cfg_data[TICK_W-1:0];
                CFG_MINUTE_TENS_LIMIT: mt_limit_reg   <= cfg_data[DIGIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.tick_limit        = tick_limit_reg;
    assign cfg.minute_tens_limit = mt_limit_reg;

endmodule
`default_nettype wire

@@ src/bmk_in_reg.sv @@
// Input register stage for incoming items.
`default_nettype none
module bmk_in_reg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire bmk_pkg::in_item_t in_item,
    output logic             item_vld,
    output bmk_pkg::in_item_t item,
    input  wire logic        take
);
    import bmk_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    assign in_ready = !vld_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule
`default_nettype wire

@@ src/bmk_core.sv @@
// Clock state update (prescaler, digit cascade, keypad edit) and result register.
`default_nettype none
module bmk_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bmk_pkg::cfg_t     cfg,
    input  wire logic         item_vld,
    input  wire bmk_pkg::in_item_t item,
    output logic              take,
    output logic              out_valid,
    input  wire logic         out_ready,
    output bmk_pkg::out_item_t out_item
);
    import bmk_pkg::*;

    logic [TICK_W-1:0]  prescale_reg, prescale_next;
    logic [DIGIT_W-1:0] clock_reg [4];
    logic [DIGIT_W-1:0] clock_next [4];
    logic [DIGIT_W-1:0] entry_reg [4];
    logic [IDX_W-1:0]   entry_idx_reg, entry_idx_next;
    logic               edit_reg, edit_next;
    logic               passed, commit, digit_wr;
    logic [TICK_W:0]    pre_inc;
    logic [DIGIT_W:0]   b3, b2, b1, b0;
    logic               is_digit;
    logic [DIGIT_W-1:0] key_val;

    logic      out_vld_reg;
    out_item_t out_reg;

    assign take = item_vld && (!out_vld_reg || out_ready);

    assign pre_inc  = {1'b0, prescale_reg} + 13'd1;
    assign is_digit = (item.key_code >= KEY_ZERO) && (item.key_code <= KEY_NINE);
    assign key_val  = item.key_code[DIGIT_W-1:0];

    // ripple cascade; each stage only takes effect when the one below carried
    assign b3 = bump_digit(clock_reg[3], LIMIT_UNITS);
    assign b2 = bump_digit(clock_reg[2], LIMIT_TENS);
    assign b1 = bump_digit(clock_reg[1], LIMIT_UNITS);
    assign b0 = bump_digit(clock_reg[0], cfg.minute_tens_limit);

    always_comb
    begin
        prescale_next  = prescale_reg;
        clock_next     = clock_reg;
        entry_idx_next = entry_idx_reg;
        edit_next      = edit_reg;
        passed         = 1'b0;
        commit         = 1'b0;
        digit_wr       = 1'b0;
        case (item.mode)
            MODE_TICK:
            begin
                if (pre_inc >= {1'b0, cfg.tick_limit})
                begin
                    prescale_next = '0;
                    passed        = 1'b1;
                    clock_next[3] = b3[DIGIT_W-1:0];
                    if (b3[DIGIT_W])
                    begin
                        clock_next[2] = b2[DIGIT_W-1:0];
                        if (b2[DIGIT_W])
                        begin
                            clock_next[1] = b1[DIGIT_W-1:0];
                            if (b1[DIGIT_W])
                            begin
                                clock_next[0] = b0[DIGIT_W-1:0];
                            end
                        end
                    end
                end
                else
                begin
                    prescale_next = pre_inc[TICK_W-1:0];
                end
            end
            MODE_KEY:
            begin
                if (edit_reg)
                begin
                    if (item.key_code == KEY_CANCEL)
                    begin
                        edit_next = 1'b0;
                    end
                    else if (item.key_code == KEY_COMMIT)
                    begin
                        if (entry_idx_reg == ENTRY_FULL)
                        begin
                            clock_next = entry_reg;
                            edit_next  = 1'b0;
                            commit     = 1'b1;
                        end
                    end
                    else if (is_digit && (entry_idx_reg < ENTRY_FULL))
                    begin
                        digit_wr       = 1'b1;
                        entry_idx_next = entry_idx_reg + 3'd1;
                    end
                end
            end
            MODE_EDIT:
            begin
                edit_next      = 1'b1;
                entry_idx_next = '0;
            end
            MODE_CLEAR:
            begin
                clock_next = '{default: '0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            clock_reg     <= '{default: '0};
            entry_idx_reg <= '0;
            edit_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prescale_reg  <= prescale_next;
                clock_reg     <= clock_next;
                entry_idx_reg <= entry_idx_next;
                edit_reg      <= edit_next;
                out_vld_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // entry buffer has no reset; only read after four writes in one session
    always_ff @(posedge clk)
    begin
        if (take && digit_wr)
        begin
            entry_reg[entry_idx_reg[1:0]] <= key_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.minute_tens   <= clock_next[0];
            out_reg.minute_units  <= clock_next[1];
            out_reg.second_tens   <= clock_next[2];
            out_reg.second_units  <= clock_next[3];
            out_reg.editing       <= edit_next;
            out_reg.entered_count <= entry_idx_next;
            out_reg.second_passed <= passed;
            out_reg.committed     <= commit;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_idx_reg <= ENTRY_FULL)
        else $error("entry index beyond four digits");

    a_commit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.committed) |-> (!out_reg.editing &&
                                                out_reg.entered_count == ENTRY_FULL))
        else $error("commit result with open edit or short entry");

    a_pass_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && passed) |=> (prescale_reg == '0))
        else $error("prescaler not restarted after a second advance");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(out_reg.committed && out_reg.second_passed))
        else $error("tick and commit flagged on the same item");
`endif

endmodule
`default_nettype wire

@@ test/bcd_mmss_clock_keypad_set_test.sv @@
// Self-checking testbench for the BCD mm:ss keypad clock, with a predictor and random stimulus.
module bcd_mmss_clock_keypad_set_test;
    import bmk_pkg::*;

    localparam int LONG_HOLD   = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int CHUNK       = 100;

    logic clk;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bcd_mmss_clock_keypad_set dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the clock, the edit buffer and the registers
    logic [TICK_W-1:0]  run_count = '0;
    logic [DIGIT_W-1:0] clock_digit [4] = '{default: 4'd0};
    logic [DIGIT_W-1:0] key_buffer [4] = '{default: 4'd0};
    logic [IDX_W-1:0]   keys_held = '0;
    logic               session_open = 1'b0;
    logic [TICK_W-1:0]  ticks_per_second = TICK_LIMIT_RESET;
    logic [DIGIT_W-1:0] tens_wrap = MINUTE_TENS_LIMIT_RESET;

    in_item_t  pending_events [$];
    out_item_t expected_results [$];

    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;

    int error_count = 0;
    int items_taken = 0;
    int seconds_seen = 0;
    int commits_seen = 0;
    int settings_run = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one item to the predicted state and returns the result it should produce.
    function automatic out_item_t step_clock(in_item_t ev);
        out_item_t          r;
        logic [TICK_W:0]    next_count;
        logic [DIGIT_W-1:0] wrap_at;
        logic               carry;
        r = '0;
        case (ev.mode)
            MODE_TICK:
            begin
                next_count = {1'b0, run_count} + 1'b1;
                if (next_count >= {1'b0, ticks_per_second})
                begin
                    run_count = '0;
                    r.second_passed = 1'b1;
                    carry = 1'b1;
                    // ripple from seconds units up to minute tens
                    for (int i = 3; i >= 0; i--)
                    begin
                        if (carry)
                        begin
                            wrap_at = (i == 0) ? tens_wrap : (i == 2) ? LIMIT_TENS : LIMIT_UNITS;
                            clock_digit[i] = clock_digit[i] + 4'd1;
                            carry = (clock_digit[i] >= wrap_at);
                            if (carry)
                            begin
                                clock_digit[i] = '0;
                            end
                        end
                    end
                end
                else
                begin
                    run_count = next_count[TICK_W-1:0];
                end
            end
            MODE_KEY:
            begin
                if (session_open)
                begin
                    if (ev.key_code == KEY_CANCEL)
                    begin
                        session_open = 1'b0;
                    end
                    else if (ev.key_code == KEY_COMMIT)
                    begin
                        if (keys_held == ENTRY_FULL)
                        begin
                            clock_digit = key_buffer;
                            session_open = 1'b0;
                            r.committed = 1'b1;
                        end
                    end
                    else if (ev.key_code >= KEY_ZERO && ev.key_code <= KEY_NINE)
                    begin
                        if (keys_held < ENTRY_FULL)
                        begin
                            key_buffer[keys_held[1:0]] = ev.key_code[3:0];
                            keys_held = keys_held + 1'b1;
                        end
                    end
                end
            end
            MODE_EDIT:
            begin
                session_open = 1'b1;
                keys_held = '0;
            end
            default:
            begin
                clock_digit = '{default: 4'd0};
            end
        endcase
        r.minute_tens   = clock_digit[0];
        r.minute_units  = clock_digit[1];
        r.second_tens   = clock_digit[2];
        r.second_units  = clock_digit[3];
        r.editing       = session_open;
        r.entered_count = keys_held;
        return r;
    endfunction

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver: offers the next item at the falling edge, holds it until taken
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_item  <= pending_events.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        out_item_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(step_clock(in_item));
                items_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("minute_tens", want.minute_tens, out_item.minute_tens);
                    check_field("minute_units", want.minute_units, out_item.minute_units);
                    check_field("second_tens", want.second_tens, out_item.second_tens);
                    check_field("second_units", want.second_units, out_item.second_units);
                    check_field("editing", want.editing, out_item.editing);
                    check_field("entered_count", want.entered_count, out_item.entered_count);
                    check_field("second_passed", want.second_passed, out_item.second_passed);
                    check_field("committed", want.committed, out_item.committed);
                    if (want.second_passed)
                    begin
                        seconds_seen++;
                    end
                    if (want.committed)
                    begin
                        commits_seen++;
                    end
                end
            end
        end
    end

    // watchdog: ends the run after too many cycles with no accept on either side
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_event(logic [1:0] m, logic [7:0] k);
        pending_events.push_back(in_item_t'{mode: m, key_code: k});
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == CFG_TICK_LIMIT)
        begin
            ticks_per_second = val;
        end
        else
        begin
            tens_wrap = val[DIGIT_W-1:0];
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic start_setting(logic [11:0] tl, logic [3:0] ml, int send_pct, int stall_pct);
        wait_idle();
        write_reg(CFG_TICK_LIMIT, tl);
        write_reg(CFG_MINUTE_TENS_LIMIT, 12'(ml));
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        settings_run++;
    endtask

    // Mostly tick runs and edit sessions, some clears and raw noise.
    task automatic queue_random(int budget);
        int n;
        int pick;
        int len;
        logic [3:0] d;
        n = 0;
        while (n < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                len = $urandom_range(1, 12);
                repeat (len) push_event(MODE_TICK, 8'($urandom));
                n += len;
            end
            else if (pick < 75)
            begin
                push_event(MODE_EDIT, 8'($urandom));
                len = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 4;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(7) == 0)
                    begin
                        push_event(MODE_KEY, 8'($urandom));
                    end
                    if ($urandom_range(5) == 0)
                    begin
                        push_event(MODE_TICK, 8'($urandom));
                    end
                    // half the digits sit just below a wrap so commits land near rollover
                    case (i)
                        0:       d = tens_wrap - 4'd1;
                        2:       d = 4'd5;
                        default: d = 4'd9;
                    endcase
                    if ($urandom_range(1) == 1 || d > 4'd9)
                    begin
                        d = 4'($urandom_range(9));
                    end
                    push_event(MODE_KEY, KEY_ZERO + 8'(d));
                end
                pick = $urandom_range(9);
                if (pick < 7)
                begin
                    push_event(MODE_KEY, KEY_COMMIT);
                end
                else if (pick == 7)
                begin
                    push_event(MODE_KEY, KEY_CANCEL);
                end
                else if (pick == 8)
                begin
                    push_event(MODE_CLEAR, 8'($urandom));
                end
                n += len + 2;
            end
            else if (pick < 82)
            begin
                push_event(MODE_CLEAR, 8'($urandom));
                n++;
            end
            else
            begin
                push_event(2'($urandom), 8'($urandom));
                n++;
            end
        end
    endtask

    task automatic run_chunks(int chunks);
        repeat (chunks)
        begin
            queue_random(CHUNK);
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed items at the reset register values
        push_event(MODE_TICK, 8'h00);
        push_event(MODE_KEY, KEY_ZERO + 8'd5);  // key with no session open
        push_event(MODE_CLEAR, 8'hFF);
        push_event(MODE_EDIT, 8'h00);
        push_event(MODE_KEY, 8'h00);
        push_event(MODE_KEY, 8'hFF);
        push_event(MODE_KEY, KEY_ZERO - 8'd1);
        push_event(MODE_KEY, KEY_NINE + 8'd1);
        push_event(MODE_KEY, KEY_COMMIT);       // too early, session stays open
        push_event(MODE_KEY, KEY_ZERO + 8'd1);
        push_event(MODE_KEY, KEY_ZERO + 8'd2);
        push_event(MODE_KEY, KEY_ZERO + 8'd3);
        push_event(MODE_KEY, KEY_ZERO + 8'd4);
        push_event(MODE_KEY, KEY_ZERO + 8'd5);  // fifth digit dropped
        push_event(MODE_KEY, KEY_COMMIT);
        push_event(MODE_KEY, KEY_COMMIT);       // session already closed
        push_event(MODE_EDIT, 8'h5A);
        push_event(MODE_KEY, KEY_ZERO + 8'd9);
        push_event(MODE_EDIT, 8'hA5);           // restart drops the digit
        push_event(MODE_KEY, KEY_CANCEL);
        push_event(MODE_EDIT, 8'h00);
        push_event(MODE_KEY, KEY_ZERO);
        push_event(MODE_KEY, KEY_NINE);
        push_event(MODE_KEY, KEY_ZERO + 8'd5);
        push_event(MODE_KEY, KEY_NINE);
        push_event(MODE_CLEAR, 8'h00);          // clear leaves the session alone
        push_event(MODE_KEY, KEY_COMMIT);
        wait_idle();

        // build up the prescaler, then lower the limit beneath it
        repeat (30) push_event(MODE_TICK, 8'h00);
        start_setting(12'd8, 4'd1, 0, 0);
        repeat (20) push_event(MODE_TICK, 8'h00);
        wait_idle();

        start_setting(12'd1, 4'd10, 0, 0);
        hold_requests++;
        run_chunks(3);
        start_setting(12'd2, 4'd6, 51, 0);
        run_chunks(3);
        start_setting(12'd1, 4'd1, 0, 51);
        run_chunks(3);
        start_setting(12'd7, 4'd3, 7, 7);
        run_chunks(3);
        start_setting(12'd4095, 4'd9, 51, 0);
        run_chunks(2);
        start_setting(12'd3, 4'd10, 0, 0);
        run_chunks(3);
        start_setting(12'd1, 4'd2, 0, 51);
        hold_requests++;
        run_chunks(3);

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Covered %0d items across %0d register settings:", items_taken, settings_run);
        $display("%0d second advances and %0d committed edits checked.",
                 seconds_seen, commits_seen);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
